>>> rtl/core/fehl_pkg.sv
`default_nettype none

package fehl_pkg;

    localparam int BUFFER_DEPTH = 65536;
    localparam int SAMPLE_BITS  = 24;
    localparam int ADDR_W       = $clog2(BUFFER_DEPTH);
    localparam int CFG_W        = 16;
    localparam int CFG_IDX_W    = 2;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_DELAY_WHOLE   = 2'd0,
        CFG_DELAY_FRAC    = 2'd1,
        CFG_FEEDBACK_GAIN = 2'd2,
        CFG_FILTER_POLE   = 2'd3
    } cfg_index_t;

    typedef enum logic [3:0] {
        S_IDLE,
        S_RD0,
        S_RD1,
        S_RD2,
        S_RD3,
        S_TAP3,
        S_COEF,
        S_H1,
        S_H2,
        S_H3,
        S_LPA,
        S_LPB,
        S_FB,
        S_DONE
    } state_t;

    typedef struct packed {
        logic                   we;
        logic                   re;
        logic [ADDR_W-1:0]      addr;
        logic [SAMPLE_BITS-1:0] wdata;
    } mem_req_t;

endpackage

`default_nettype wire

>>> rtl/core/fehl_delay_mem.sv
`default_nettype none

module fehl_delay_mem (
    input  wire                                     clk,
    input  wire                                     rst_n,
    input  fehl_pkg::mem_req_t                      req,
    output logic signed [fehl_pkg::SAMPLE_BITS-1:0] rd_data
);
    import fehl_pkg::*;

    logic [SAMPLE_BITS-1:0] mem [BUFFER_DEPTH];
    logic [SAMPLE_BITS-1:0] raw_reg;
    logic                   rd_valid_reg;
    logic                   rd_valid_next;
    // entries are written in address order from zero, so a count marks what holds data
    logic [ADDR_W:0]        fill_reg;
    logic [ADDR_W:0]        fill_next;

    always_ff @(posedge clk)
    begin
        if (req.we)
        begin
            mem[req.addr] <= req.wdata;
        end
        else if (req.re)
        begin
            raw_reg <= mem[req.addr];
        end
    end

    always_comb
    begin
        fill_next     = fill_reg;
        rd_valid_next = rd_valid_reg;
        if (req.we && !fill_reg[ADDR_W])
        begin
            fill_next = fill_reg + 1'b1;
        end
        if (req.re && !req.we)
        begin
            rd_valid_next = fill_reg[ADDR_W] || ({1'b0, req.addr} < fill_reg);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fill_reg     <= '0;
            rd_valid_reg <= 1'b0;
        end
        else
        begin
            fill_reg     <= fill_next;
            rd_valid_reg <= rd_valid_next;
        end
    end

    // never-written entries read as zero
    assign rd_data = rd_valid_reg ? $signed(raw_reg) : '0;

endmodule

`default_nettype wire

>>> rtl/core/feedback_echo_hermite_lowpass_core.sv
// Feedback echo with a cubic Hermite fractional delay tap and a one-pole
// lowpass in the feedback path, audio samples signed Q1.23.
// Input channel: in_valid / in_stall with in_sample. An item is taken when
// in_valid is high and in_stall low. Output channel: out_valid / out_stall
// with out_sample, one result item for each input item, in order.
// Configuration: cfg_we writes cfg_data into the register chosen by
// cfg_index (0 delay_whole, 1 delay_frac, 2 feedback_gain, 3 filter_pole);
// write only while no item is in flight.
// Timing: an item passes the states RD0 to RD3, TAP3, COEF, H1 to H3,
// LPA, LPB, FB and DONE, where its result is registered, before the next
// item is accepted in IDLE. The pace is set by the single port of the
// delay memory (four tap reads and one write back per item) and by one shared
// 17x32 multiplier that serves the three Horner steps, the lowpass and the gain.
// A new item may be accepted while the previous result waits in the output
// register; if the receiver stalls, the block holds its finished item in
// the last step until the output register is free.
// Reset: registers, write position and lowpass state clear at once; the
// delay memory reads as zero until each entry has been written, so no
// clearing pass is needed and the block is ready right after reset.
`default_nettype none

module feedback_echo_hermite_lowpass_core (
    input  wire                                     clk,
    input  wire                                     rst_n,
    input  wire                                     in_valid,
    output logic                                    in_stall,
    input  wire signed [fehl_pkg::SAMPLE_BITS-1:0]  in_sample,
    output logic                                    out_valid,
    input  wire                                     out_stall,
    output logic signed [fehl_pkg::SAMPLE_BITS-1:0] out_sample,
    input  wire                                     cfg_we,
    input  wire [fehl_pkg::CFG_IDX_W-1:0]           cfg_index,
    input  wire [fehl_pkg::CFG_W-1:0]               cfg_data
);
    import fehl_pkg::*;

    localparam int MUL_X_W = 17;
    localparam int MUL_Y_W = 32;
    localparam int PROD_W  = MUL_X_W + MUL_Y_W;
    localparam int ACC_W   = PROD_W + 1;
    localparam int T_W     = 30;
    localparam int C_W     = 28;
    localparam int FB_W    = 34;
    localparam int SUM_W   = FB_W + 1;

    state_t state_reg;
    state_t state_next;

    logic [15:0]        delay_whole_reg;
    logic [15:0]        delay_frac_reg;
    logic signed [15:0] feedback_gain_reg;
    logic signed [15:0] filter_pole_reg;

    logic [ADDR_W-1:0]  wp_reg;
    logic signed [31:0] lp_state_reg;

    logic signed [SAMPLE_BITS-1:0] in_reg;
    logic signed [SAMPLE_BITS-1:0] y0_reg;
    logic signed [SAMPLE_BITS-1:0] y1_reg;
    logic signed [SAMPLE_BITS-1:0] y2_reg;
    logic signed [SAMPLE_BITS-1:0] y3_reg;
    logic signed [C_W-1:0]         c1_reg;
    logic signed [C_W-1:0]         c2_reg;
    logic signed [C_W-1:0]         c3_reg;
    logic signed [T_W-1:0]         t_reg;
    logic signed [PROD_W-1:0]      acc_reg;
    logic signed [FB_W-1:0]        fb_reg;

    logic                          out_valid_reg;
    logic signed [SAMPLE_BITS-1:0] out_sample_reg;

    mem_req_t                      mem_req;
    logic signed [SAMPLE_BITS-1:0] rd_data;

    logic                          done_go;
    logic [31:0]                   dly_ext;
    logic [31:0]                   dly_sat;
    logic [ADDR_W-1:0]             tap_base;

    logic signed [C_W-1:0]     y0e;
    logic signed [C_W-1:0]     y1e;
    logic signed [C_W-1:0]     y2e;
    logic signed [C_W-1:0]     y3e;
    logic signed [MUL_X_W-1:0] pole_abs;
    logic signed [MUL_X_W-1:0] lp_gain;
    logic signed [T_W:0]       echo_wide;
    logic signed [MUL_X_W-1:0] mul_x;
    logic signed [MUL_Y_W-1:0] mul_y;
    logic signed [PROD_W-1:0]  prod;
    logic signed [ACC_W-1:0]   h_addend;
    logic signed [ACC_W-1:0]   h_sum;
    logic signed [ACC_W-1:0]   h_rnd;
    logic signed [ACC_W-1:0]   lp_sum;
    logic signed [ACC_W-1:0]   lp_rnd;
    logic signed [31:0]        lp_sat;
    logic signed [ACC_W-1:0]   fb_rnd;
    logic signed [SUM_W-1:0]   out_sum;
    logic signed [SAMPLE_BITS-1:0] out_sat;

    fehl_delay_mem u_mem (
        .clk     (clk),
        .rst_n   (rst_n),
        .req     (mem_req),
        .rd_data (rd_data)
    );

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            delay_whole_reg   <= '0;
            delay_frac_reg    <= '0;
            feedback_gain_reg <= '0;
            filter_pole_reg   <= '0;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index_t'(cfg_index))
                CFG_DELAY_WHOLE:   delay_whole_reg   <= cfg_data;
                CFG_DELAY_FRAC:    delay_frac_reg    <= cfg_data;
                CFG_FEEDBACK_GAIN: feedback_gain_reg <= $signed(cfg_data);
                CFG_FILTER_POLE:   filter_pole_reg   <= $signed(cfg_data);
                default:           ;
            endcase
        end
    end

    // tap addresses around the saturated delay
    assign dly_ext  = 32'(delay_whole_reg);
    assign dly_sat  = (dly_ext > 32'(BUFFER_DEPTH - 4)) ? 32'(BUFFER_DEPTH - 4) : dly_ext;
    assign tap_base = wp_reg - dly_sat[ADDR_W-1:0];

    assign done_go = (state_reg == S_DONE) && (!out_valid_reg || !out_stall);

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE: if (in_valid) state_next = S_RD0;
            S_RD0:  state_next = S_RD1;
            S_RD1:  state_next = S_RD2;
            S_RD2:  state_next = S_RD3;
            S_RD3:  state_next = S_TAP3;
            S_TAP3: state_next = S_COEF;
            S_COEF: state_next = S_H1;
            S_H1:   state_next = S_H2;
            S_H2:   state_next = S_H3;
            S_H3:   state_next = S_LPA;
            S_LPA:  state_next = S_LPB;
            S_LPB:  state_next = S_FB;
            S_FB:   state_next = S_DONE;
            S_DONE: if (done_go) state_next = S_IDLE;
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // outputs of the sequencer: memory port and multiplier operands
    always_comb
    begin
        mem_req       = '0;
        mem_req.addr  = tap_base;
        mem_req.wdata = out_sat;
        mul_x         = $signed({1'b0, delay_frac_reg});
        mul_y         = 32'(c3_reg);
        h_addend      = ACC_W'(c2_reg) <<< 16;
        unique case (state_reg)
            S_RD0:
            begin
                mem_req.re   = 1'b1;
                mem_req.addr = tap_base + ADDR_W'(1);
            end
            S_RD1:
            begin
                mem_req.re   = 1'b1;
                mem_req.addr = tap_base;
            end
            S_RD2:
            begin
                mem_req.re   = 1'b1;
                mem_req.addr = tap_base - ADDR_W'(1);
            end
            S_RD3:
            begin
                mem_req.re   = 1'b1;
                mem_req.addr = tap_base - ADDR_W'(2);
            end
            S_H2:
            begin
                mul_y    = 32'(t_reg);
                h_addend = ACC_W'(c1_reg) <<< 16;
            end
            S_H3:
            begin
                mul_y    = 32'(t_reg);
                h_addend = ACC_W'(y1_reg) <<< 17;
            end
            S_LPA:
            begin
                mul_x = lp_gain;
                mul_y = 32'(echo_wide >>> 1);
            end
            S_LPB:
            begin
                mul_x = MUL_X_W'(filter_pole_reg);
                mul_y = lp_state_reg;
            end
            S_FB:
            begin
                mul_x = MUL_X_W'(feedback_gain_reg);
                mul_y = lp_state_reg;
            end
            S_DONE:
            begin
                mem_req.we   = done_go;
                mem_req.addr = wp_reg;
            end
            default: ;
        endcase
    end

    assign in_stall = (state_reg != S_IDLE);

    assign y0e = C_W'(y0_reg);
    assign y1e = C_W'(y1_reg);
    assign y2e = C_W'(y2_reg);
    assign y3e = C_W'(y3_reg);

    assign pole_abs  = filter_pole_reg[15] ? -MUL_X_W'(filter_pole_reg)
                                           : MUL_X_W'(filter_pole_reg);
    assign lp_gain   = 17'sd32768 - pole_abs;
    assign echo_wide = (T_W+1)'(t_reg) + (T_W+1)'(1);

    // shared multiplier
    assign prod = mul_x * mul_y;

    // horner step with round half up
    assign h_sum = ACC_W'(prod) + h_addend;
    assign h_rnd = (h_sum + ACC_W'(32768)) >>> 16;

    // lowpass update, saturated to 32 bits
    assign lp_sum = ACC_W'(acc_reg) + ACC_W'(prod);
    assign lp_rnd = (lp_sum + ACC_W'(16384)) >>> 15;
    always_comb
    begin
        if (lp_rnd > ACC_W'(32'sh7fff_ffff))
        begin
            lp_sat = 32'sh7fff_ffff;
        end
        else if (lp_rnd < ACC_W'(32'sh8000_0000))
        begin
            lp_sat = 32'sh8000_0000;
        end
        else
        begin
            lp_sat = lp_rnd[31:0];
        end
    end

    assign fb_rnd = (ACC_W'(prod) + ACC_W'(16384)) >>> 15;

    // input plus echo, saturated to the sample range
    assign out_sum = SUM_W'(in_reg) + SUM_W'(fb_reg);
    always_comb
    begin
        if (out_sum > SUM_W'($signed({1'b0, {(SAMPLE_BITS-1){1'b1}}})))
        begin
            out_sat = {1'b0, {(SAMPLE_BITS-1){1'b1}}};
        end
        else if (out_sum < SUM_W'($signed({1'b1, {(SAMPLE_BITS-1){1'b0}}})))
        begin
            out_sat = {1'b1, {(SAMPLE_BITS-1){1'b0}}};
        end
        else
        begin
            out_sat = out_sum[SAMPLE_BITS-1:0];
        end
    end

    // datapath registers
    always_ff @(posedge clk)
    begin
        case (state_reg)
            S_IDLE: if (in_valid) in_reg <= in_sample;
            S_RD1:  y0_reg <= rd_data;
            S_RD2:  y1_reg <= rd_data;
            S_RD3:  y2_reg <= rd_data;
            S_TAP3: y3_reg <= rd_data;
            S_COEF:
            begin
                c1_reg <= y2e - y0e;
                c2_reg <= (y0e <<< 1) - ((y1e <<< 2) + y1e) + (y2e <<< 2) - y3e;
                c3_reg <= (y3e - y0e) + ((y1e - y2e) <<< 1) + (y1e - y2e);
            end
            S_H1, S_H2, S_H3: t_reg <= h_rnd[T_W-1:0];
            S_LPA:  acc_reg <= prod;
            S_FB:   fb_reg  <= fb_rnd[FB_W-1:0];
            default: ;
        endcase
        if (done_go)
        begin
            out_sample_reg <= out_sat;
        end
    end

    // stream state and output handshake
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg        <= '0;
            lp_state_reg  <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (state_reg == S_LPB)
            begin
                lp_state_reg <= lp_sat;
            end
            if (done_go)
            begin
                wp_reg        <= wp_reg + 1'b1;
                out_valid_reg <= 1'b1;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    assign out_valid  = out_valid_reg;
    assign out_sample = out_sample_reg;

endmodule

`default_nettype wire
